FILE: rtl/value_noise_fbm_defines.svh
// Assertion macros shared by the value noise checker.
// No dependencies.
`ifndef VALUE_NOISE_FBM_DEFINES_SVH
`define VALUE_NOISE_FBM_DEFINES_SVH

// checked outside reset
`define VNF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge
`define VNF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vnf_pkg.sv
// Shared constants and types for the value noise pipeline.
// No dependencies.
package vnf_pkg;
   localparam int BASE_WAVELENGTH = 64;
   localparam int MAX_OCTAVES     = 8;
   localparam int WEIGHT_BITS     = 18;
   localparam int COORD_W         = 16;
   localparam int GRID_W          = 17;
   localparam int ACC_W           = 54;
   localparam int MIX_LAT         = 3;
   localparam int CELL_LAT        = 9;

   localparam logic [63:0] HASH_MUL_X = 64'h9E3779B185EBCA87;
   localparam logic [63:0] HASH_MUL_Y = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] MIX_ADD    = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL1   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL2   = 64'h94D049BB133111EB;
   localparam logic signed [10:0] AMPLITUDE = 11'sd760;

   typedef enum logic [3:0] {
      CSR_SEED  = 4'd0,
      CSR_COUNT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [ACC_W-1:0]   acc;
   } chain_type;
endpackage

FILE: rtl/vnf_mix.sv
// Pipelined 64-bit splitmix finalizer, three register stages.
// Depends on vnf_pkg.
module vnf_mix import vnf_pkg::*; (
   input  logic        clock,
   input  logic [63:0] mix_in,
   output logic [63:0] mix_out
);
   logic [63:0] t0, u0, m1, u1, m2;
   logic [63:0] p_lo_ff, q_lo_ff, mix_out_ff;
   logic [31:0] p_h1_ff, p_h2_ff, q_h1_ff, q_h2_ff;
   logic [63:0] p_lo_in, q_lo_in;
   logic [31:0] p_h1_in, p_h2_in, q_h1_in, q_h2_in;

   always_comb begin
      t0 = mix_in + MIX_ADD;
      u0 = t0 ^ (t0 >> 30);
      p_lo_in = 64'(u0[31:0]) * 64'(MIX_MUL1[31:0]);
      p_h1_in = 32'(64'(u0[63:32]) * 64'(MIX_MUL1[31:0]));
      p_h2_in = 32'(64'(u0[31:0]) * 64'(MIX_MUL1[63:32]));
      m1 = p_lo_ff + {p_h1_ff + p_h2_ff, 32'b0};
      u1 = m1 ^ (m1 >> 27);
      q_lo_in = 64'(u1[31:0]) * 64'(MIX_MUL2[31:0]);
      q_h1_in = 32'(64'(u1[63:32]) * 64'(MIX_MUL2[31:0]));
      q_h2_in = 32'(64'(u1[31:0]) * 64'(MIX_MUL2[63:32]));
      m2 = q_lo_ff + {q_h1_ff + q_h2_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      p_lo_ff    <= p_lo_in;
      p_h1_ff    <= p_h1_in;
      p_h2_ff    <= p_h2_in;
      q_lo_ff    <= q_lo_in;
      q_h1_ff    <= q_h1_in;
      q_h2_ff    <= q_h2_in;
      mix_out_ff <= m2 ^ (m2 >> 31);
   end

   assign mix_out = mix_out_ff;
endmodule

FILE: rtl/vnf_cell.sv
// One octave of the noise chain: hashes the lattice corners, blends them and
// adds the scaled term to the running sum when octave_count exceeds OCTAVE. Depends on vnf_pkg and vnf_mix.
module vnf_cell import vnf_pkg::*; #(
   parameter int OCTAVE     = 0,
   parameter int WAVELENGTH = BASE_WAVELENGTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] seed,
   input  logic [3:0]  octave_count,
   input  chain_type   chain_in,
   output chain_type   chain_out
);
   localparam int W  = ((WAVELENGTH >> OCTAVE) < 1) ? 1 : (WAVELENGTH >> OCTAVE);
   localparam int RW = (W > 1) ? $clog2(W) : 1;
   localparam int NW = 3 * RW + 2 + WEIGHT_BITS;
   localparam logic [NW-1:0] WCUBE = NW'(W * W * W);

   function automatic logic [WEIGHT_BITS:0] smooth(input logic [RW-1:0] r);
      logic [NW-1:0] rr;
      logic [NW-1:0] num;
      rr  = NW'(r);
      num = (rr * rr * (NW'(3 * W) - NW'(2) * rr)) << WEIGHT_BITS;
      return (WEIGHT_BITS + 1)'(num / WCUBE);
   endfunction

   // stage A: lattice cell and weights
   logic [GRID_W-1:0]    a_gx_ff, a_gy_ff;
   logic [WEIGHT_BITS:0] a_fx_ff, a_fy_ff;
   chain_type            a_ch_ff;
   // stage B: hash multiplier partials
   logic [63:0]          b_px_lo_ff, b_py_lo_ff;
   logic [31:0]          b_px_hi_ff, b_py_hi_ff;
   logic [WEIGHT_BITS:0] b_fx_ff, b_fy_ff;
   chain_type            b_ch_ff;
   // alignment with the mixers
   logic [WEIGHT_BITS:0] c_fx_ff [MIX_LAT];
   logic [WEIGHT_BITS:0] c_fy_ff [MIX_LAT];
   chain_type            c_ch_ff [MIX_LAT];
   // stage D: corner differences times fx
   logic signed [24:0]   d_a_ff, d_c_ff;
   logic signed [45:0]   d_pn_ff, d_ps_ff;
   logic [WEIGHT_BITS:0] d_fy_ff;
   chain_type            d_ch_ff;
   // stage E: row blends, difference times fy
   logic signed [46:0]   e_n_ff;
   logic signed [67:0]   e_p_ff;
   chain_type            e_ch_ff;
   // stage F: scaled octave value
   logic signed [58:0]   f_t_ff;
   chain_type            f_ch_ff;
   chain_type            g_ch_ff;

   logic [63:0] oseed, hx, hx1, hy, hy1;
   logic [63:0] h00, h10, h01, h11;
   logic signed [24:0] ca, cb, cc, cd;
   logic signed [25:0] dab, dcd;
   logic signed [19:0] fxs, fys;
   logic signed [45:0] d_pn_in, d_ps_in;
   logic signed [46:0] n_e, s_e;
   logic signed [47:0] ns_e;
   logic signed [67:0] e_p_in, v_f;
   logic signed [47:0] v40;
   logic signed [58:0] f_t_in, term;
   chain_type g_ch_in;

   vnf_mix u_seed (.clock(clock), .mix_in(seed ^ 64'(OCTAVE)), .mix_out(oseed));

   always_comb begin
      hx  = b_px_lo_ff + {b_px_hi_ff, 32'b0};
      hy  = b_py_lo_ff + {b_py_hi_ff, 32'b0};
      hx1 = hx + HASH_MUL_X;
      hy1 = hy + HASH_MUL_Y;
   end

   vnf_mix u_h00 (.clock(clock), .mix_in(oseed ^ hx  ^ hy ), .mix_out(h00));
   vnf_mix u_h10 (.clock(clock), .mix_in(oseed ^ hx1 ^ hy ), .mix_out(h10));
   vnf_mix u_h01 (.clock(clock), .mix_in(oseed ^ hx  ^ hy1), .mix_out(h01));
   vnf_mix u_h11 (.clock(clock), .mix_in(oseed ^ hx1 ^ hy1), .mix_out(h11));

   always_comb begin
      // (h >> 39) - 2^24 is the top 25 bits with the sign bit flipped
      ca  = $signed({~h00[63], h00[62:39]});
      cb  = $signed({~h10[63], h10[62:39]});
      cc  = $signed({~h01[63], h01[62:39]});
      cd  = $signed({~h11[63], h11[62:39]});
      dab = 26'(cb) - 26'(ca);
      dcd = 26'(cd) - 26'(cc);
      fxs = $signed({1'b0, c_fx_ff[MIX_LAT-1]});
      d_pn_in = dab * fxs;
      d_ps_in = dcd * fxs;

      n_e  = $signed({{4{d_a_ff[24]}}, d_a_ff, {WEIGHT_BITS{1'b0}}}) + 47'(d_pn_ff);
      s_e  = $signed({{4{d_c_ff[24]}}, d_c_ff, {WEIGHT_BITS{1'b0}}}) + 47'(d_ps_ff);
      ns_e = 48'(s_e) - 48'(n_e);
      fys  = $signed({1'b0, d_fy_ff});
      e_p_in = ns_e * fys;

      v_f  = $signed({{3{e_n_ff[46]}}, e_n_ff, {WEIGHT_BITS{1'b0}}}) + e_p_ff;
      v40  = v_f[67:20];
      f_t_in = v40 * AMPLITUDE;

      term = f_t_ff >>> OCTAVE;
      g_ch_in = f_ch_ff;
      if ({1'b0, octave_count} > 5'(OCTAVE))
         g_ch_in.acc = f_ch_ff.acc + term[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      a_gx_ff <= GRID_W'(chain_in.x / W);
      a_gy_ff <= GRID_W'(chain_in.y / W);
      a_fx_ff <= smooth(RW'(chain_in.x % W));
      a_fy_ff <= smooth(RW'(chain_in.y % W));

      b_px_lo_ff <= 64'(a_gx_ff) * 64'(HASH_MUL_X[31:0]);
      b_px_hi_ff <= 32'(64'(a_gx_ff) * 64'(HASH_MUL_X[63:32]));
      b_py_lo_ff <= 64'(a_gy_ff) * 64'(HASH_MUL_Y[31:0]);
      b_py_hi_ff <= 32'(64'(a_gy_ff) * 64'(HASH_MUL_Y[63:32]));
      b_fx_ff    <= a_fx_ff;
      b_fy_ff    <= a_fy_ff;

      c_fx_ff[0] <= b_fx_ff;
      c_fy_ff[0] <= b_fy_ff;
      for (int i = 1; i < MIX_LAT; i++) begin
         c_fx_ff[i] <= c_fx_ff[i-1];
         c_fy_ff[i] <= c_fy_ff[i-1];
      end

      d_a_ff  <= ca;
      d_c_ff  <= cc;
      d_pn_ff <= d_pn_in;
      d_ps_ff <= d_ps_in;
      d_fy_ff <= c_fy_ff[MIX_LAT-1];

      e_n_ff <= n_e;
      e_p_ff <= e_p_in;

      f_t_ff <= f_t_in;

      if (reset) begin
         a_ch_ff.valid <= 1'b0;
         b_ch_ff.valid <= 1'b0;
         for (int i = 0; i < MIX_LAT; i++)
            c_ch_ff[i].valid <= 1'b0;
         d_ch_ff.valid <= 1'b0;
         e_ch_ff.valid <= 1'b0;
         f_ch_ff.valid <= 1'b0;
         g_ch_ff.valid <= 1'b0;
      end else begin
         a_ch_ff    <= chain_in;
         b_ch_ff    <= a_ch_ff;
         c_ch_ff[0] <= b_ch_ff;
         for (int i = 1; i < MIX_LAT; i++)
            c_ch_ff[i] <= c_ch_ff[i-1];
         d_ch_ff <= c_ch_ff[MIX_LAT-1];
         e_ch_ff <= d_ch_ff;
         f_ch_ff <= e_ch_ff;
         g_ch_ff <= g_ch_in;
      end
   end

   assign chain_out = g_ch_ff;
endmodule

FILE: rtl/value_noise_fbm.sv
// Fractal value noise sampler: one chain cell per octave.
// A request is registered, passes through every cell in turn, and the result is registered before rsp_valid.
// Throughput: one request per cycle; busy stays low, each cell's pipeline
// takes a new sample every cycle and the result strobes for one cycle.
// Reset: synchronous; clears the pipeline, noise_seed to 0, octave_count to 4.
// Config takes effect for requests started the cycle after the write.
module value_noise_fbm import vnf_pkg::*; #(
   parameter int BASE_WAVE  = BASE_WAVELENGTH,
   parameter int MAX_OCTAVES = vnf_pkg::MAX_OCTAVES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   output logic               rsp_valid,
   output logic [23:0]        rsp_noise_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [63:0]        csr_data
);
   logic [63:0] seed_ff;
   logic [3:0]  count_ff;
   chain_type   in_ff;
   chain_type   links [MAX_OCTAVES+1];
   logic        rsp_valid_ff;
   logic [23:0] rsp_noise_value_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 64'd0;
         count_ff <= 4'd4;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEED:  seed_ff  <= csr_data;
            CSR_COUNT: count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_ff.x   <= req_coord_x;
      in_ff.y   <= req_coord_y;
      in_ff.acc <= '0;
      rsp_noise_value_ff <= links[MAX_OCTAVES].acc[51:28];
      if (reset) begin
         in_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_ff.valid  <= start && !busy;
         rsp_valid_ff <= links[MAX_OCTAVES].valid;
      end
   end

   assign links[0] = in_ff;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
      vnf_cell #(.OCTAVE(k), .WAVELENGTH(BASE_WAVE)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .seed         (seed_ff),
         .octave_count (count_ff),
         .chain_in     (links[k]),
         .chain_out    (links[k+1])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;
endmodule

FILE: rtl/vnf_checker.sv
// Port-level checks for value_noise_fbm, bound to the top level.
// Depends on vnf_pkg and value_noise_fbm_defines.svh.
`include "value_noise_fbm_defines.svh"
module vnf_checker import vnf_pkg::*; #(
   parameter int MAX_OCTAVES = vnf_pkg::MAX_OCTAVES
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [COORD_W-1:0] req_coord_x,
   input logic [COORD_W-1:0] req_coord_y,
   input logic               rsp_valid,
   input logic [23:0]        rsp_noise_value,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [3:0]         csr_index,
   input logic [63:0]        csr_data
);
   localparam int LAT = CELL_LAT * MAX_OCTAVES + 2;

   logic req_ok;
   assign req_ok = start && !busy;

   `VNF_ASSERT(a_no_stall, clock, reset, !busy, "request stalled")
   `VNF_ASSERT(a_rsp_has_req, clock, reset, rsp_valid |-> $past(req_ok, LAT), "response without request")
   `VNF_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid, "response after reset")
   `VNF_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> ($signed(rsp_noise_value) <= 24'sd6225920 && $signed(rsp_noise_value) >= -24'sd6225920), "response out of range")
endmodule

bind value_noise_fbm vnf_checker #(.MAX_OCTAVES(MAX_OCTAVES)) u_vnf_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for value_noise_fbm: fractal value noise per sample.
// Depends on vnf_pkg and the value_noise_fbm RTL; holds its own noise predictor.
module tb;
   import vnf_pkg::*;

   localparam logic [3:0] CSR_UNUSED = 4'd9;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
   } sample_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_coord_x = '0;
   logic [15:0] req_coord_y = '0;
   logic        rsp_valid;
   logic [23:0] rsp_noise_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   sample_t     pending_q[$];
   logic [23:0] noise_q[$];
   logic [63:0] seed_reg = '0;
   logic [3:0]  count_reg = 4'd4;
   bit          taken = 1'b0;
   bit          burst = 1'b0;
   int          gap = 0;
   int          idle_cycles = 0;
   int          errors = 0;

   value_noise_fbm uut (.*);

   always #2 clock = ~clock;

   function automatic logic [63:0] splitmix(input logic [63:0] v);
      v = v + MIX_ADD;
      v = (v ^ (v >> 30)) * MIX_MUL1;
      v = (v ^ (v >> 27)) * MIX_MUL2;
      return v ^ (v >> 31);
   endfunction

   function automatic longint lattice(input logic [63:0] s, input logic [63:0] gx,
                                      input logic [63:0] gy);
      logic [63:0] h;
      h = splitmix(s ^ (gx * HASH_MUL_X) ^ (gy * HASH_MUL_Y));
      return longint'({39'b0, h[63:39]}) - (longint'(1) << 24);
   endfunction

   function automatic longint smooth(input longint r, input longint w);
      longint num;
      num = r * r * (3 * w - 2 * r);
      return (num << WEIGHT_BITS) / (w * w * w);
   endfunction

   function automatic logic [23:0] noise_predict(input logic [15:0] x, input logic [15:0] y);
      longint w, acc, one, fx, fy, a, b, c, d, n, s, v, gx, gy;
      logic [63:0] oseed;
      int cnt;
      w = BASE_WAVELENGTH;
      acc = 0;
      one = longint'(1) << WEIGHT_BITS;
      cnt = (count_reg > MAX_OCTAVES) ? MAX_OCTAVES : count_reg;
      for (int k = 0; k < cnt; k++) begin
         oseed = splitmix(seed_reg ^ 64'(k));
         gx = x / w;
         gy = y / w;
         fx = smooth(x % w, w);
         fy = smooth(y % w, w);
         a = lattice(oseed, gx, gy);
         b = lattice(oseed, gx + 1, gy);
         c = lattice(oseed, gx, gy + 1);
         d = lattice(oseed, gx + 1, gy + 1);
         n = a * one + (b - a) * fx;
         s = c * one + (d - c) * fx;
         v = n * one + (s - n) * fy;
         acc += ((v >>> 20) * 760) >>> k;
         w = (w / 2 < 1) ? 1 : w / 2;
      end
      return 24'(acc >>> 28);
   endfunction

   // monitor: request and config acceptance, result check, watchdog
   always @(posedge clock) begin
      logic [23:0] want;
      taken <= 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SEED) seed_reg = csr_data;
            else if (csr_index == CSR_COUNT) count_reg = csr_data[3:0];
         end
         if (start && !busy) begin
            noise_q.push_back(noise_predict(req_coord_x, req_coord_y));
            taken <= 1'b1;
         end
         if (rsp_valid) begin
            if (noise_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d", $time,
                        $signed(rsp_noise_value));
               errors++;
            end else begin
               want = noise_q.pop_front();
               if (want !== rsp_noise_value) begin
                  $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time,
                           $signed(want), $signed(rsp_noise_value));
                  errors++;
               end
            end
         end
         if ((start && !busy) || rsp_valid || (pending_q.size() == 0 && noise_q.size() == 0))
            idle_cycles = 0;
         else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset || (start && !taken)) begin
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_q.size() != 0) begin
         sample_t item;
         item = pending_q.pop_front();
         req_coord_x <= item.x;
         req_coord_y <= item.y;
         start <= 1'b1;
         gap <= burst ? 0 : $urandom_range(0, 17);
      end else begin
         start <= 1'b0;
      end
   end

   task automatic csr_write(input logic [3:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_sample(input logic [15:0] x, input logic [15:0] y);
      sample_t item;
      item.x = x;
      item.y = y;
      pending_q.push_back(item);
   endtask

   task automatic add_random(input int n);
      logic [15:0] x, y;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: begin x = $urandom_range(0, 255); y = $urandom_range(0, 255); end
            1: begin
               x = 16'($urandom_range(0, 1023) * 64 + $urandom_range(0, 1) * 63);
               y = 16'($urandom_range(0, 1023) * 64 + $urandom_range(0, 1) * 63);
            end
            default: begin x = $urandom; y = $urandom; end
         endcase
         add_sample(x, y);
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || noise_q.size() != 0 || start) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset, directed corners and cell edges
      add_sample(16'h0000, 16'h0000);
      add_sample(16'hFFFF, 16'hFFFF);
      add_sample(16'h0000, 16'hFFFF);
      add_sample(16'hFFFF, 16'h0000);
      add_sample(16'd63, 16'd64);
      add_sample(16'd64, 16'd63);
      add_sample(16'd1, 16'd1);
      add_sample(16'd32, 16'd32);
      add_sample(16'hAAAA, 16'h5555);
      add_sample(16'h5555, 16'hAAAA);
      drain();

      // unknown index must not change anything
      csr_write(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_COUNT, 64'd8);
      add_sample(16'h0000, 16'h0000);
      add_sample(16'hFFFF, 16'hFFFF);
      add_sample(16'd127, 16'd1);
      drain();
      csr_write(CSR_COUNT, 64'd0);
      add_sample(16'h1234, 16'h4321);
      add_sample(16'hFFFF, 16'h0000);
      drain();
      csr_write(CSR_COUNT, 64'd15);
      add_sample(16'h1234, 16'h4321);
      add_sample(16'hFFFF, 16'hFFFF);
      drain();
      csr_write(CSR_COUNT, 64'hFFFF_FFFF_FFFF_FFF9);
      add_sample(16'h0F0F, 16'hF0F0);
      drain();
      csr_write(CSR_COUNT, 64'd1);
      csr_write(CSR_SEED, 64'd0);
      add_sample(16'hFFFF, 16'hFFFF);
      add_sample(16'h0000, 16'h0000);
      drain();

      for (int p = 0; p < 10; p++) begin
         csr_write(CSR_SEED, {$urandom, $urandom});
         csr_write(CSR_COUNT, $urandom_range(0, 15));
         if ($urandom_range(0, 3) == 0) csr_write(4'($urandom_range(2, 15)), {$urandom, $urandom});
         burst = (p % 3 == 1);
         add_random(140);
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && noise_q.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/vnf_pkg.sv
rtl/vnf_mix.sv
rtl/vnf_cell.sv
rtl/value_noise_fbm.sv
rtl/vnf_checker.sv
tb/tb.sv
